@@ design/bps_pkg.sv @@
// ----------------------------------------------------------------------------
// Board power sequencer package
// Shared pin positions, phase codes, register indexes and the result type.
// ----------------------------------------------------------------------------
package bps_pkg;

   // Positions of the driven lines in the pin vector
   localparam int PIN_VIN_OK    = 0;
   localparam int PIN_BUTTON    = 1;
   localparam int PIN_DISCHARGE = 2;
   localparam int PIN_EN5V      = 3;
   localparam int PIN_EN3V3     = 4;
   localparam int PIN_EN2V5     = 5;
   localparam int PIN_EN1V8     = 6;
   localparam int PIN_EN1V2     = 7;
   localparam int PIN_RESET_OUT = 8;
   localparam int PIN_RESET_IN  = 9;
   localparam int PIN_FORCE_REC = 10;
   localparam int PIN_COUNT     = 11;

   localparam int PHASE_BITS = 4;

   // Sequencing phases
   localparam logic [PHASE_BITS-1:0] PH_WAIT_VIN     = 4'd0;
   localparam logic [PHASE_BITS-1:0] PH_WAIT_CARRIER = 4'd1;
   localparam logic [PHASE_BITS-1:0] PH_START_5V     = 4'd2;
   localparam logic [PHASE_BITS-1:0] PH_OTHER_RAILS  = 4'd3;
   localparam logic [PHASE_BITS-1:0] PH_RESET_DELAY  = 4'd4;
   localparam logic [PHASE_BITS-1:0] PH_RESET_PULSE  = 4'd5;
   localparam logic [PHASE_BITS-1:0] PH_ON           = 4'd6;
   localparam logic [PHASE_BITS-1:0] PH_EMERGENCY    = 4'd7;
   localparam logic [PHASE_BITS-1:0] PH_POWERDOWN    = 4'd8;
   localparam logic [PHASE_BITS-1:0] PH_RECOVERY     = 4'd9;

   // Register indexes on the configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VIN_GOOD       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VIN_DELTA      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAIL_GOOD      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_DELAY    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_PULSE    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECOVERY_PULSE = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECOVERY_HOLD  = 3'd6;

   // Register reset values
   localparam int RST_VIN_GOOD       = 903;
   localparam int RST_VIN_DELTA      = 6;
   localparam int RST_RAIL_GOOD      = 2048;
   localparam int RST_RESET_DELAY    = 100;
   localparam int RST_RESET_PULSE    = 200;
   localparam int RST_RECOVERY_PULSE = 800;
   localparam int RST_RECOVERY_HOLD  = 5000;

   // Pin levels after reset: reset, recovery and button lines high
   localparam logic [PIN_COUNT-1:0] PINS_RESET =
      (PIN_COUNT'(1) << PIN_RESET_OUT) | (PIN_COUNT'(1) << PIN_RESET_IN) |
      (PIN_COUNT'(1) << PIN_FORCE_REC) | (PIN_COUNT'(1) << PIN_BUTTON);

   localparam int RSP_BITS = 16;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic [PIN_COUNT-1:0]  pins;
   } result_type;

endpackage

@@ design/bps_csr.sv @@
// ----------------------------------------------------------------------------
// Board power sequencer configuration registers
// Thresholds and period counts, written one register per beat.
// ----------------------------------------------------------------------------
module bps_csr
   import bps_pkg::*;
#(
   parameter int ADC_BITS   = 12,
   parameter int TIMER_BITS = 16,
   parameter int CSR_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [CSR_INDEX_BITS-1:0] wr_index,
   input  logic [CSR_BITS-1:0]       wr_data,
   output logic [ADC_BITS-1:0]       vin_good_code,
   output logic [ADC_BITS-1:0]       vin_stable_delta,
   output logic [ADC_BITS-1:0]       rail_good_code,
   output logic [TIMER_BITS-1:0]     reset_delay_periods,
   output logic [TIMER_BITS-1:0]     reset_pulse_periods,
   output logic [TIMER_BITS-1:0]     recovery_pulse_periods,
   output logic [TIMER_BITS-1:0]     recovery_hold_periods
);

   logic [ADC_BITS-1:0]   vin_good_ff, vin_delta_ff, rail_good_ff;
   logic [TIMER_BITS-1:0] rst_delay_ff, rst_pulse_ff, rec_pulse_ff, rec_hold_ff;
   logic [ADC_BITS-1:0]   data_adc;
   logic [TIMER_BITS-1:0] data_timer;

   assign data_adc   = wr_data[ADC_BITS-1:0];
   assign data_timer = wr_data[TIMER_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vin_good_ff  <= ADC_BITS'(RST_VIN_GOOD);
         vin_delta_ff <= ADC_BITS'(RST_VIN_DELTA);
         rail_good_ff <= ADC_BITS'(RST_RAIL_GOOD);
         rst_delay_ff <= TIMER_BITS'(RST_RESET_DELAY);
         rst_pulse_ff <= TIMER_BITS'(RST_RESET_PULSE);
         rec_pulse_ff <= TIMER_BITS'(RST_RECOVERY_PULSE);
         rec_hold_ff  <= TIMER_BITS'(RST_RECOVERY_HOLD);
      end else if (wr_en) begin
         case (wr_index)
            CSR_VIN_GOOD:       vin_good_ff  <= data_adc;
            CSR_VIN_DELTA:      vin_delta_ff <= data_adc;
            CSR_RAIL_GOOD:      rail_good_ff <= data_adc;
            CSR_RESET_DELAY:    rst_delay_ff <= data_timer;
            CSR_RESET_PULSE:    rst_pulse_ff <= data_timer;
            CSR_RECOVERY_PULSE: rec_pulse_ff <= data_timer;
            CSR_RECOVERY_HOLD:  rec_hold_ff  <= data_timer;
            default: ;
         endcase
      end
   end

   assign vin_good_code          = vin_good_ff;
   assign vin_stable_delta       = vin_delta_ff;
   assign rail_good_code         = rail_good_ff;
   assign reset_delay_periods    = rst_delay_ff;
   assign reset_pulse_periods    = rst_pulse_ff;
   assign recovery_pulse_periods = rec_pulse_ff;
   assign recovery_hold_periods  = rec_hold_ff;

endmodule

@@ design/bps_core.sv @@
// ----------------------------------------------------------------------------
// Board power sequencer core
// Sequencing state and the per-period update of phase, timers and pins.
// ----------------------------------------------------------------------------
module bps_core
   import bps_pkg::*;
#(
   parameter int ADC_BITS   = 12,
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [ADC_BITS-1:0]   vin_code,
   input  logic [ADC_BITS-1:0]   rail_1v8_code,
   input  logic                  carrier_power_on,
   input  logic                  power_good_5v,
   input  logic                  recovery_request,
   input  logic [ADC_BITS-1:0]   vin_good_code,
   input  logic [ADC_BITS-1:0]   vin_stable_delta,
   input  logic [ADC_BITS-1:0]   rail_good_code,
   input  logic [TIMER_BITS-1:0] reset_delay_periods,
   input  logic [TIMER_BITS-1:0] reset_pulse_periods,
   input  logic [TIMER_BITS-1:0] recovery_pulse_periods,
   input  logic [TIMER_BITS-1:0] recovery_hold_periods,
   output result_type            result
);

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [ADC_BITS-1:0]   prev_vin_ff, prev_vin_in;
   logic [TIMER_BITS-1:0] phase_timer_ff, phase_timer_in;
   logic [TIMER_BITS-1:0] rec_timer_ff, rec_timer_in;
   logic                  rec_armed_ff, rec_armed_in;
   logic [PIN_COUNT-1:0]  pins_ff, pins_in;

   logic [PHASE_BITS-1:0] handled;
   logic [PHASE_BITS-1:0] seq_phase;
   logic [ADC_BITS-1:0]   vin_diff;
   logic                  counting;
   logic                  count_done;
   logic                  vin_low;

   assign counting = (phase_ff == PH_RESET_DELAY) || (phase_ff == PH_RESET_PULSE) ||
                     (phase_ff == PH_RECOVERY);
   assign count_done = (phase_timer_ff <= TIMER_BITS'(1));
   assign vin_low    = (vin_code < vin_good_code);
   assign vin_diff   = (vin_code >= prev_vin_ff) ? (vin_code - prev_vin_ff)
                                                 : (prev_vin_ff - vin_code);

   always_comb begin
      phase_in       = phase_ff;
      prev_vin_in    = prev_vin_ff;
      phase_timer_in = phase_timer_ff;
      rec_timer_in   = rec_timer_ff;
      rec_armed_in   = rec_armed_ff;
      pins_in        = pins_ff;
      handled        = phase_ff;
      seq_phase      = phase_ff;

      // The recovery hold runs down in every period, whatever the phase
      if (rec_armed_ff) begin
         if (rec_timer_ff <= TIMER_BITS'(1)) begin
            rec_timer_in           = '0;
            rec_armed_in           = 1'b0;
            pins_in[PIN_FORCE_REC] = 1'b1;
         end else begin
            rec_timer_in = rec_timer_ff - TIMER_BITS'(1);
         end
      end

      if (counting) begin
         // Counted phases ignore every input field of the beat.
         phase_timer_in = count_done ? '0 : phase_timer_ff - TIMER_BITS'(1);
         if (count_done) begin
            case (phase_ff)
               PH_RESET_DELAY: begin
                  pins_in[PIN_RESET_OUT] = 1'b0;
                  phase_timer_in         = reset_pulse_periods;
                  phase_in               = PH_RESET_PULSE;
               end
               PH_RESET_PULSE: begin
                  pins_in[PIN_RESET_OUT] = 1'b1;
                  phase_in               = PH_ON;
               end
               default: begin
                  pins_in[PIN_RESET_IN] = 1'b1;
                  phase_in              = PH_POWERDOWN;
                  rec_timer_in          = recovery_hold_periods;
                  rec_armed_in          = 1'b1;
               end
            endcase
         end
      end else begin
         if (recovery_request && (phase_ff == PH_ON)) begin
            seq_phase = PH_RECOVERY;
         end
         if (vin_low) begin
            seq_phase = PH_EMERGENCY;
         end
         pins_in[PIN_VIN_OK] = !vin_low;
         if ((seq_phase > PH_WAIT_CARRIER) && !carrier_power_on) begin
            seq_phase = PH_POWERDOWN;
         end
         handled  = seq_phase;
         phase_in = seq_phase;

         case (seq_phase)
            PH_WAIT_VIN: begin
               if (!vin_low && (vin_diff < vin_stable_delta)) begin
                  pins_in[PIN_BUTTON] = 1'b0;
                  phase_in            = PH_WAIT_CARRIER;
               end
            end
            PH_WAIT_CARRIER: begin
               if (carrier_power_on) begin
                  pins_in[PIN_BUTTON] = 1'b1;
                  phase_in            = PH_START_5V;
               end
            end
            PH_START_5V: begin
               pins_in[PIN_DISCHARGE] = 1'b0;
               pins_in[PIN_EN5V]      = 1'b1;
               if (power_good_5v) begin
                  phase_in = PH_OTHER_RAILS;
               end
            end
            PH_OTHER_RAILS: begin
               pins_in[PIN_EN3V3] = 1'b1;
               pins_in[PIN_EN2V5] = 1'b1;
               pins_in[PIN_EN1V8] = 1'b1;
               pins_in[PIN_EN1V2] = 1'b1;
               if (rail_1v8_code > rail_good_code) begin
                  phase_timer_in = reset_delay_periods;
                  phase_in       = PH_RESET_DELAY;
               end
            end
            PH_EMERGENCY, PH_POWERDOWN: begin
               // An emergency also drops vin_ok, which is already low here.
               pins_in[PIN_EN1V8]     = 1'b0;
               pins_in[PIN_EN5V]      = 1'b0;
               pins_in[PIN_EN3V3]     = 1'b0;
               pins_in[PIN_EN2V5]     = 1'b0;
               pins_in[PIN_EN1V2]     = 1'b0;
               pins_in[PIN_DISCHARGE] = 1'b1;
               phase_in               = PH_WAIT_CARRIER;
            end
            PH_RECOVERY: begin
               pins_in[PIN_FORCE_REC] = 1'b0;
               pins_in[PIN_RESET_IN]  = 1'b0;
               phase_timer_in         = recovery_pulse_periods;
               rec_armed_in           = 1'b0;
               rec_timer_in           = '0;
            end
            default: ;
         endcase
         prev_vin_in = vin_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT_VIN;
         prev_vin_ff    <= '0;
         phase_timer_ff <= '0;
         rec_timer_ff   <= '0;
         rec_armed_ff   <= 1'b0;
         pins_ff        <= PINS_RESET;
      end else if (step) begin
         phase_ff       <= phase_in;
         prev_vin_ff    <= prev_vin_in;
         phase_timer_ff <= phase_timer_in;
         rec_timer_ff   <= rec_timer_in;
         rec_armed_ff   <= rec_armed_in;
         pins_ff        <= pins_in;
      end
   end

   assign result.phase = handled;
   assign result.pins  = pins_in;

endmodule

@@ design/board_power_sequencer.sv @@
// ----------------------------------------------------------------------------
// Board power sequencer
// One control period per request beat; one beat of pin levels per period.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     ADC codes and pin levels
//  rsp      out        rsp_tvalid/tready     driven line levels and phase
//  csr      in         csr_valid/ready       register index and value
//
// Each request beat is latched in an input register and handled by the
// single sequencer update, whose result lands in the output register.
// One beat per cycle is sustained while the output is not stalled. A
// stalled output holds the input register, which then drops req_tready.
// Synchronous reset restores the register defaults and the power-up
// phase; csr_ready is always high.
// ----------------------------------------------------------------------------
module board_power_sequencer
   import bps_pkg::*;
#(
   parameter int ADC_BITS   = 12,
   parameter int TIMER_BITS = 16,
   localparam int REQ_BITS  = ((2 * ADC_BITS + 3 + 7) / 8) * 8,
   localparam int CSR_BITS  = (ADC_BITS > TIMER_BITS) ? ADC_BITS : TIMER_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // vin_code, rail_1v8_code, carrier_power_on, power_good_5v,
   // recovery_request, zero padding
   input  logic [REQ_BITS-1:0]       req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // vin_ok, power_button, rail_discharge, rail_5v_enable, rail_3v3_enable,
   // rail_2v5_enable, rail_1v8_enable, rail_1v2_enable, reset_out_line,
   // reset_in_line, force_recovery, phase[3:0], zero padding
   output logic [RSP_BITS-1:0]       rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]       csr_data
);

   localparam int RAIL_LSB = ADC_BITS;
   localparam int FLAG_LSB = 2 * ADC_BITS;

   logic                  s1_valid_ff, s1_valid_in;
   logic [ADC_BITS-1:0]   s1_vin_ff, s1_rail_ff;
   logic                  s1_carrier_ff, s1_pg5_ff, s1_req_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff;
   result_type            result;
   logic                  req_accept;
   logic                  out_free;
   logic                  step;

   logic [ADC_BITS-1:0]   vin_good_code, vin_stable_delta, rail_good_code;
   logic [TIMER_BITS-1:0] reset_delay_periods, reset_pulse_periods;
   logic [TIMER_BITS-1:0] recovery_pulse_periods, recovery_hold_periods;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_vin_ff     <= req_tdata[ADC_BITS-1:0];
         s1_rail_ff    <= req_tdata[RAIL_LSB +: ADC_BITS];
         s1_carrier_ff <= req_tdata[FLAG_LSB];
         s1_pg5_ff     <= req_tdata[FLAG_LSB + 1];
         s1_req_ff     <= req_tdata[FLAG_LSB + 2];
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   bps_csr #(
      .ADC_BITS   (ADC_BITS),
      .TIMER_BITS (TIMER_BITS),
      .CSR_BITS   (CSR_BITS)
   ) u_csr (
      .clock                  (clock),
      .reset                  (reset),
      .wr_en                  (csr_valid && csr_ready),
      .wr_index               (csr_index),
      .wr_data                (csr_data),
      .vin_good_code          (vin_good_code),
      .vin_stable_delta       (vin_stable_delta),
      .rail_good_code         (rail_good_code),
      .reset_delay_periods    (reset_delay_periods),
      .reset_pulse_periods    (reset_pulse_periods),
      .recovery_pulse_periods (recovery_pulse_periods),
      .recovery_hold_periods  (recovery_hold_periods)
   );

   bps_core #(
      .ADC_BITS   (ADC_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock                  (clock),
      .reset                  (reset),
      .step                   (step),
      .vin_code               (s1_vin_ff),
      .rail_1v8_code          (s1_rail_ff),
      .carrier_power_on       (s1_carrier_ff),
      .power_good_5v          (s1_pg5_ff),
      .recovery_request       (s1_req_ff),
      .vin_good_code          (vin_good_code),
      .vin_stable_delta       (vin_stable_delta),
      .rail_good_code         (rail_good_code),
      .reset_delay_periods    (reset_delay_periods),
      .reset_pulse_periods    (reset_pulse_periods),
      .recovery_pulse_periods (recovery_pulse_periods),
      .recovery_hold_periods  (recovery_hold_periods),
      .result                 (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_BITS - $bits(result_type)){1'b0}}, rsp_data_ff};

   // A period waiting on a stalled output must stay in the input register.
   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !step |=> s1_valid_ff && $stable(s1_vin_ff))
      else $error("pending period lost while output stalled");

   // The 5 V rail is never enabled while the discharge path is on.
   a_no_discharge_on_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.pins[PIN_EN5V] && rsp_data_ff.pins[PIN_DISCHARGE]))
      else $error("5 V rail enabled with discharge active");

   // An emergency period reports a bad supply with every rail off.
   a_emergency_shutdown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.phase == PH_EMERGENCY) |->
         !rsp_data_ff.pins[PIN_VIN_OK] && rsp_data_ff.pins[PIN_DISCHARGE] &&
         !rsp_data_ff.pins[PIN_EN3V3] && !rsp_data_ff.pins[PIN_EN1V8])
      else $error("emergency period left a rail enabled");

   // Once powered on, reset out has been released.
   a_on_reset_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.phase == PH_ON) |-> rsp_data_ff.pins[PIN_RESET_OUT])
      else $error("reset out still asserted in the on phase");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Board power sequencer testbench
// Drives control periods on the request stream and configuration writes on
// the register port, predicts every line level and phase beat in a
// scoreboard, and compares each result beat field by field. A short directed
// run walks through start-up, loss of supply, loss of carrier power and
// recovery; random runs under several register settings follow.
// ----------------------------------------------------------------------------
module tb_top;
   import bps_pkg::*;

   localparam int ADC_W   = 12;
   localparam int TIMER_W = 16;
   localparam int REQ_W   = 32;
   localparam int ADC_MAX = 4095;
   localparam int MAX_GAP = 18;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // vin_code, rail_1v8_code, carrier_power_on, power_good_5v,
   // recovery_request, zero padding
   logic [REQ_W-1:0]          req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // vin_ok, power_button, rail_discharge, rail_5v_enable, rail_3v3_enable,
   // rail_2v5_enable, rail_1v8_enable, rail_1v2_enable, reset_out_line,
   // reset_in_line, force_recovery, phase[3:0], zero padding
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [TIMER_W-1:0]        csr_data   = '0;

   // Set while both sides should run without gaps.
   bit no_gaps = 1'b0;

   class power_seq_scoreboard;
      logic [ADC_W-1:0]     vin_good, vin_delta, rail_good;
      logic [TIMER_W-1:0]   delay_len, pulse_len, rec_pulse_len, rec_hold_len;
      logic [PHASE_BITS-1:0] phase_q;
      logic [ADC_W-1:0]     last_vin;
      logic [TIMER_W-1:0]   step_timer, hold_timer;
      bit                   hold_armed;
      logic [PIN_COUNT-1:0] pins;
      result_type           expected_levels[$];
      string                line_name[PIN_COUNT];
      int                   errors;

      function new();
         vin_good      = ADC_W'(RST_VIN_GOOD);
         vin_delta     = ADC_W'(RST_VIN_DELTA);
         rail_good     = ADC_W'(RST_RAIL_GOOD);
         delay_len     = TIMER_W'(RST_RESET_DELAY);
         pulse_len     = TIMER_W'(RST_RESET_PULSE);
         rec_pulse_len = TIMER_W'(RST_RECOVERY_PULSE);
         rec_hold_len  = TIMER_W'(RST_RECOVERY_HOLD);
         phase_q       = PH_WAIT_VIN;
         last_vin      = '0;
         step_timer    = '0;
         hold_timer    = '0;
         hold_armed    = 1'b0;
         pins          = PINS_RESET;
         errors        = 0;
         line_name     = '{"vin_ok", "power_button", "rail_discharge",
                           "rail_5v_enable", "rail_3v3_enable", "rail_2v5_enable",
                           "rail_1v8_enable", "rail_1v2_enable", "reset_out_line",
                           "reset_in_line", "force_recovery"};
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] idx, logic [TIMER_W-1:0] value);
         case (idx)
            CSR_VIN_GOOD:       vin_good      = value[ADC_W-1:0];
            CSR_VIN_DELTA:      vin_delta     = value[ADC_W-1:0];
            CSR_RAIL_GOOD:      rail_good     = value[ADC_W-1:0];
            CSR_RESET_DELAY:    delay_len     = value;
            CSR_RESET_PULSE:    pulse_len     = value;
            CSR_RECOVERY_PULSE: rec_pulse_len = value;
            CSR_RECOVERY_HOLD:  rec_hold_len  = value;
            default: ;
         endcase
      endfunction

      function bit counting();
         return phase_q == PH_RESET_DELAY || phase_q == PH_RESET_PULSE ||
                phase_q == PH_RECOVERY;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      // A loaded count of zero or one ends on the very next period.
      function bit step_count_ends();
         if (step_timer <= 1) begin
            step_timer = '0;
            return 1'b1;
         end
         step_timer = step_timer - 1'b1;
         return 1'b0;
      endfunction

      function void tick_recovery_hold();
         if (!hold_armed)
            return;
         if (hold_timer <= 1) begin
            hold_timer = '0;
            hold_armed = 1'b0;
            pins[PIN_FORCE_REC] = 1'b1;
         end else begin
            hold_timer = hold_timer - 1'b1;
         end
      endfunction

      function void rails_down();
         pins[PIN_EN1V8]     = 1'b0;
         pins[PIN_EN5V]      = 1'b0;
         pins[PIN_EN3V3]     = 1'b0;
         pins[PIN_EN2V5]     = 1'b0;
         pins[PIN_EN1V2]     = 1'b0;
         pins[PIN_DISCHARGE] = 1'b1;
      endfunction

      // Advances the sequencer by one accepted period and queues its result.
      function void advance(logic [ADC_W-1:0] vin, logic [ADC_W-1:0] rail,
                            bit carrier, bit pg5, bit rec_req);
         logic [PHASE_BITS-1:0] handled;
         int                    diff;
         result_type            want;
         handled = phase_q;
         if (counting()) begin
            // Timed phases ignore every input and leave the last supply code alone.
            tick_recovery_hold();
            if (phase_q == PH_RESET_DELAY) begin
               if (step_count_ends()) begin
                  pins[PIN_RESET_OUT] = 1'b0;
                  step_timer = pulse_len;
                  phase_q = PH_RESET_PULSE;
               end
            end else if (phase_q == PH_RESET_PULSE) begin
               if (step_count_ends()) begin
                  pins[PIN_RESET_OUT] = 1'b1;
                  phase_q = PH_ON;
               end
            end else if (step_count_ends()) begin
               pins[PIN_RESET_IN] = 1'b1;
               phase_q = PH_POWERDOWN;
               hold_timer = rec_hold_len;
               hold_armed = 1'b1;
            end
         end else begin
            diff = (vin >= last_vin) ? int'(vin) - int'(last_vin)
                                     : int'(last_vin) - int'(vin);
            if (rec_req && phase_q == PH_ON)
               phase_q = PH_RECOVERY;
            if (vin < vin_good) begin
               pins[PIN_VIN_OK] = 1'b0;
               phase_q = PH_EMERGENCY;
            end else begin
               pins[PIN_VIN_OK] = 1'b1;
            end
            if (phase_q > PH_WAIT_CARRIER && !carrier)
               phase_q = PH_POWERDOWN;
            tick_recovery_hold();
            handled = phase_q;
            case (phase_q)
               PH_WAIT_VIN: begin
                  if (vin >= vin_good && diff < int'(vin_delta)) begin
                     pins[PIN_BUTTON] = 1'b0;
                     phase_q = PH_WAIT_CARRIER;
                  end
               end
               PH_WAIT_CARRIER: begin
                  if (carrier) begin
                     pins[PIN_BUTTON] = 1'b1;
                     phase_q = PH_START_5V;
                  end
               end
               PH_START_5V: begin
                  pins[PIN_DISCHARGE] = 1'b0;
                  pins[PIN_EN5V] = 1'b1;
                  if (pg5)
                     phase_q = PH_OTHER_RAILS;
               end
               PH_OTHER_RAILS: begin
                  pins[PIN_EN3V3] = 1'b1;
                  pins[PIN_EN2V5] = 1'b1;
                  pins[PIN_EN1V8] = 1'b1;
                  pins[PIN_EN1V2] = 1'b1;
                  if (rail > rail_good) begin
                     step_timer = delay_len;
                     phase_q = PH_RESET_DELAY;
                  end
               end
               // An emergency also drops vin_ok and then shuts the rails down like a powerdown.
               PH_EMERGENCY: begin
                  pins[PIN_VIN_OK] = 1'b0;
                  rails_down();
                  phase_q = PH_WAIT_CARRIER;
               end
               PH_POWERDOWN: begin
                  rails_down();
                  phase_q = PH_WAIT_CARRIER;
               end
               PH_RECOVERY: begin
                  pins[PIN_FORCE_REC] = 1'b0;
                  pins[PIN_RESET_IN] = 1'b0;
                  step_timer = rec_pulse_len;
                  hold_armed = 1'b0;
                  hold_timer = '0;
               end
               default: ;
            endcase
            last_vin = vin;
         end
         want.pins  = pins;
         want.phase = handled;
         expected_levels.push_back(want);
      endfunction

      function void check_beat(logic [RSP_BITS-1:0] data);
         result_type got, want;
         got = result_type'(data[PHASE_BITS+PIN_COUNT-1:0]);
         if (expected_levels.size() == 0) begin
            $error("rsp beat %h arrived with no result expected", data);
            errors++;
            return;
         end
         want = expected_levels.pop_front();
         for (int k = 0; k < PIN_COUNT; k++) begin
            if (got.pins[k] !== want.pins[k]) begin
               $error("%s: expected %0b, got %0b", line_name[k], want.pins[k], got.pins[k]);
               errors++;
            end
         end
         if (got.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
            errors++;
         end
      endfunction
   endclass

   power_seq_scoreboard sb = new();

   board_power_sequencer #(
      .ADC_BITS   (ADC_W),
      .TIMER_BITS (TIMER_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(12 * 3000000);
      $display("[board_power_sequencer] ERROR");
      $finish;
   end

   // Valid stays high from one beat to the next unless a gap is drawn.
   task automatic send_period(input logic [ADC_W-1:0] vin, input logic [ADC_W-1:0] rail,
                              input bit carrier, input bit pg5, input bit rec_req);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {5'b0, rec_req, pg5, carrier, rail, vin};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.advance(vin, rail, carrier, pg5, rec_req);
   endtask

   // Mostly a valid, slowly drifting supply, so that start-up gets through.
   task automatic send_random_period();
      int               v;
      logic [ADC_W-1:0] rail;
      bit               rec_req;
      if ($urandom_range(0, 99) < 8) begin
         v = $urandom_range(0, ADC_MAX);
      end else begin
         v = (sb.last_vin >= sb.vin_good) ? int'(sb.last_vin)
                                          : int'($urandom_range(sb.vin_good, ADC_MAX));
         v = v + int'($urandom_range(0, 6)) - 3;
         if (v < int'(sb.vin_good))
            v = sb.vin_good;
         if (v > ADC_MAX)
            v = ADC_MAX;
      end
      if ($urandom_range(0, 1) == 0)
         rail = ADC_W'($urandom_range(0, ADC_MAX));
      else
         rail = ADC_W'($urandom_range(sb.rail_good, ADC_MAX));
      rec_req = (sb.phase_q == PH_ON) ? ($urandom_range(0, 99) < 20)
                                      : ($urandom_range(0, 99) < 8);
      send_period(ADC_W'(v), rail, $urandom_range(0, 99) < 94,
                  $urandom_range(0, 99) < 60, rec_req);
   endtask

   // Registers are only written once every expected beat has come back.
   task automatic program_registers(input int vin_good, input int vin_delta,
                                    input int rail_good, input int delay_len,
                                    input int pulse_len, input int rec_pulse_len,
                                    input int rec_hold_len);
      logic [CSR_INDEX_BITS-1:0] idx[7];
      int                        value[7];
      idx   = '{CSR_VIN_GOOD, CSR_VIN_DELTA, CSR_RAIL_GOOD, CSR_RESET_DELAY,
                CSR_RESET_PULSE, CSR_RECOVERY_PULSE, CSR_RECOVERY_HOLD};
      value = '{vin_good, vin_delta, rail_good, delay_len, pulse_len,
                rec_pulse_len, rec_hold_len};
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      for (int k = 0; k < 7; k++) begin
         csr_index <= idx[k];
         csr_data  <= TIMER_W'(value[k]);
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_register(idx[k], TIMER_W'(value[k]));
      end
      csr_valid <= 1'b0;
   endtask

   // Runs until enough periods have been acted on and no timed phase is
   // still counting, so that the next register write finds the block idle.
   task automatic run_random_periods(input int count);
      int active;
      bit timed;
      active = 0;
      while (active < count || sb.counting()) begin
         timed   = sb.counting();
         no_gaps = (timed && sb.step_timer > 50) || (active % 100) < 15;
         send_random_period();
         if (!timed)
            active++;
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_beat(rsp_tdata);
      end
   end

   initial begin
      do @(posedge clock); while (reset);

      // Register defaults: supply stability, loss of supply and of carrier.
      send_period(903, 0, 0, 0, 0);
      send_period(908, 0, 0, 0, 0);
      send_period(902, 4095, 1, 1, 1);
      send_period(4095, 0, 0, 0, 1);
      send_period(4095, 0, 1, 0, 0);
      send_period(4095, 0, 1, 0, 0);
      send_period(4095, 0, 0, 1, 0);
      send_period(4095, 0, 1, 0, 0);
      send_period(4095, 0, 1, 1, 0);
      send_period(4095, 2048, 1, 1, 0);
      send_period(0, 4095, 1, 1, 0);

      // Short counts: full start-up, recovery, hold release, then a supply
      // drop that overrides a recovery request.
      program_registers(903, 6, 2048, 0, 1, 0, 2);
      send_period(4095, 4095, 1, 0, 0);
      send_period(4095, 4095, 1, 1, 0);
      send_period(4095, 2049, 1, 1, 0);
      send_period(0, 0, 0, 0, 1);
      send_period(0, 0, 0, 0, 0);
      send_period(4095, 0, 1, 0, 1);
      send_period(0, 0, 0, 0, 0);
      send_period(4095, 0, 1, 0, 0);
      send_period(4095, 0, 1, 0, 0);
      send_period(4095, 0, 1, 1, 0);
      send_period(4095, 4095, 1, 1, 0);
      send_period(0, 0, 0, 0, 0);
      send_period(0, 0, 0, 0, 0);
      send_period(902, 0, 1, 0, 1);

      program_registers(903, 6, 2048, 3, 2, 4, 30);
      run_random_periods(120);
      program_registers(0, 0, 0, 0, 0, 0, 0);
      run_random_periods(100);
      program_registers(4095, 4095, 4094, 12, 9, 2, 65535);
      run_random_periods(60);
      program_registers(2000, 100, 1000, 7, 5, 6, 12);
      run_random_periods(100);
      program_registers($urandom_range(0, 3000), $urandom_range(0, 4095),
                        $urandom_range(0, 4000), $urandom_range(0, 10),
                        $urandom_range(0, 10), $urandom_range(0, 10),
                        $urandom_range(0, 60));
      run_random_periods(100);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[board_power_sequencer] OK");
      else
         $display("[board_power_sequencer] ERROR");
      $finish;
   end

endmodule
